FILE: rtl/skt_pkg.sv
// shared codes, widths and types of the sorted key table
package skt_pkg;

   localparam int DEF_CAPACITY = 16;

   localparam int KIND_W   = 2;
   localparam int KEY_W    = 8;
   localparam int STATUS_W = 2;
   localparam int POS_W    = 5;
   localparam int COUNT_W  = 5;

   localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
   localparam logic [KIND_W-1:0] KIND_DELETE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_SEARCH = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd2;
   localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

   typedef struct packed {
      logic gt;
      logic eq;
   } cmp_type;

endpackage

FILE: rtl/skt_ram.sv
// generic single write port ram with registered read
module skt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/skt_cmp.sv
// shared signed key comparator
module skt_cmp (
   input  logic signed [skt_pkg::KEY_W-1:0] entry,
   input  logic signed [skt_pkg::KEY_W-1:0] key,
   output skt_pkg::cmp_type                 result
);
   import skt_pkg::*;

   always_comb begin
      result.gt = entry > key;
      result.eq = entry == key;
   end

endmodule

FILE: rtl/skt_ctrl.sv
// sequencer that walks the table one entry per cycle through the shared comparator
module skt_ctrl #(
   parameter int CAPACITY = skt_pkg::DEF_CAPACITY
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [skt_pkg::KIND_W-1:0]          req_kind,
   input  logic signed [skt_pkg::KEY_W-1:0]    req_key,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [skt_pkg::STATUS_W-1:0]        rsp_status,
   output logic [skt_pkg::POS_W-1:0]           rsp_position,
   output logic [skt_pkg::COUNT_W-1:0]         rsp_count,
   output logic                                ram_wr_en,
   output logic [$clog2(CAPACITY)-1:0]         ram_wr_addr,
   output logic [skt_pkg::KEY_W-1:0]           ram_wr_data,
   output logic [$clog2(CAPACITY)-1:0]         ram_rd_addr,
   input  logic [skt_pkg::KEY_W-1:0]           ram_rd_data,
   output logic signed [skt_pkg::KEY_W-1:0]    cmp_key,
   input  skt_pkg::cmp_type                    cmp_res
);
   import skt_pkg::*;

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);

   typedef enum logic [2:0] {
      S_IDLE, S_SCAN_UP, S_FIRST_WR, S_SCAN, S_SHIFT, S_RESULT
   } state_type;

   state_type                state_ff, state_in;
   logic [AW-1:0]            idx_ff, idx_in;
   logic [CW-1:0]            cnt_ff, cnt_in;
   logic [KIND_W-1:0]        kind_ff, kind_in;
   logic signed [KEY_W-1:0]  key_ff, key_in;
   logic [STATUS_W-1:0]      res_status_ff, res_status_in;
   logic [CW-1:0]            res_pos_ff, res_pos_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]      rsp_status_ff, rsp_status_in;
   logic [POS_W-1:0]         rsp_pos_ff, rsp_pos_in;
   logic [COUNT_W-1:0]       rsp_count_ff, rsp_count_in;

   logic [CW-1:0]            cnt_m1;
   logic [CW-1:0]            idx_ext;
   logic                     at_last;
   logic                     accept;
   logic                     out_free;

   assign cnt_m1   = cnt_ff - CW'(1);
   assign idx_ext  = CW'(idx_ff);
   assign at_last  = idx_ext == cnt_m1;
   assign req_ready = state_ff == S_IDLE;
   assign accept   = req_valid && req_ready;
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign cmp_key  = key_ff;
   assign ram_rd_addr = idx_in;

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      cnt_in        = cnt_ff;
      kind_in       = kind_ff;
      key_in        = key_ff;
      res_status_in = res_status_ff;
      res_pos_in    = res_pos_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_pos_in    = rsp_pos_ff;
      rsp_count_in  = rsp_count_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = idx_ff + AW'(1);
      ram_wr_data   = ram_rd_data;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               kind_in       = req_kind;
               key_in        = req_key;
               res_status_in = ST_OK;
               res_pos_in    = '0;
               state_in      = S_RESULT;
               unique case (req_kind) inside
                  KIND_INSERT: begin
                     if (cnt_ff == CW'(CAPACITY)) begin
                        res_status_in = ST_FULL;
                     end else if (cnt_ff == '0) begin
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = '0;
                        ram_wr_data = req_key;
                        cnt_in      = CW'(1);
                        res_pos_in  = CW'(1);
                     end else begin
                        idx_in   = cnt_m1[AW-1:0];
                        state_in = S_SCAN_UP;
                     end
                  end
                  KIND_DELETE, KIND_SEARCH: begin
                     if (cnt_ff == '0) begin
                        res_status_in = ST_EMPTY;
                     end else begin
                        idx_in   = '0;
                        state_in = S_SCAN;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_SCAN_UP: begin
            ram_wr_en = 1'b1;
            if (cmp_res.gt) begin
               if (idx_ff == '0) begin
                  state_in = S_FIRST_WR;
               end else begin
                  idx_in = idx_ff - AW'(1);
               end
            end else begin
               ram_wr_data = key_ff;
               res_pos_in  = idx_ext + CW'(2);
               cnt_in      = cnt_ff + CW'(1);
               state_in    = S_RESULT;
            end
         end
         S_FIRST_WR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = '0;
            ram_wr_data = key_ff;
            res_pos_in  = CW'(1);
            cnt_in      = cnt_ff + CW'(1);
            state_in    = S_RESULT;
         end
         S_SCAN: begin
            if (cmp_res.eq) begin
               res_pos_in = idx_ext + CW'(1);
               if (kind_ff == KIND_SEARCH) begin
                  state_in = S_RESULT;
               end else if (at_last) begin
                  cnt_in   = cnt_m1;
                  state_in = S_RESULT;
               end else begin
                  idx_in   = idx_ff + AW'(1);
                  state_in = S_SHIFT;
               end
            end else if (at_last) begin
               res_status_in = ST_NOT_FOUND;
               state_in      = S_RESULT;
            end else begin
               idx_in = idx_ff + AW'(1);
            end
         end
         S_SHIFT: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = idx_ff - AW'(1);
            if (at_last) begin
               cnt_in   = cnt_m1;
               state_in = S_RESULT;
            end else begin
               idx_in = idx_ff + AW'(1);
            end
         end
         S_RESULT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_pos_in    = POS_W'(res_pos_ff);
               rsp_count_in  = COUNT_W'(cnt_ff);
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff        <= idx_in;
      kind_ff       <= kind_in;
      key_ff        <= key_in;
      res_status_ff <= res_status_in;
      res_pos_ff    <= res_pos_in;
      rsp_status_ff <= rsp_status_in;
      rsp_pos_ff    <= rsp_pos_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_position = rsp_pos_ff;
   assign rsp_count    = rsp_count_ff;

`ifndef ASSERT_OFF
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(CAPACITY))
      else $error("key count above capacity");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_ready)
      else $error("ready again right after accept");

   a_cnt_step: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff != $past(cnt_ff)) |->
         (cnt_ff == $past(cnt_ff) + CW'(1) || cnt_ff == $past(cnt_ff) - CW'(1)))
      else $error("key count moved by more than one");

   a_wr_busy: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> (accept || state_ff != S_IDLE))
      else $error("table written while idle");

   a_full_no_write: assert property (@(posedge clock) disable iff (reset)
      (accept && req_kind == KIND_INSERT && cnt_ff == CW'(CAPACITY)) |-> !ram_wr_en)
      else $error("insert written into a full table");
`endif

endmodule

FILE: rtl/sorted_key_table_top.sv
// sorted key table top level: stream ports, table memory, comparator and sequencer
//
//  channel | dir | handshake          | payload
//  req     | in  | req_tvalid/tready  | tuser kind[1:0], tdata key[7:0]
//  rsp     | out | rsp_tvalid/tready  | tdata status[1:0] position[6:2] count[11:7]
//
// every word holds the sequencer from accept until its result is registered, so the next accept waits,
// for the walk of one table entry per cycle through the memory read port
// reset clears the key count and the result valid flag; table contents need no clearing
// a waiting result does not block the next request; the next result waits in the sequencer
module sorted_key_table_top #(
   parameter int CAPACITY = skt_pkg::DEF_CAPACITY
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // key[7:0]
   input  logic [1:0]  req_tuser,   // kind[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // status[1:0], position[6:2], count[11:7], zero[15:12]
);
   import skt_pkg::*;

   localparam int AW = $clog2(CAPACITY);

   logic [STATUS_W-1:0]      rsp_status;
   logic [POS_W-1:0]         rsp_position;
   logic [COUNT_W-1:0]       rsp_count;
   logic                     ram_wr_en;
   logic [AW-1:0]            ram_wr_addr;
   logic [KEY_W-1:0]         ram_wr_data;
   logic [AW-1:0]            ram_rd_addr;
   logic [KEY_W-1:0]         ram_rd_data;
   logic signed [KEY_W-1:0]  cmp_key;
   cmp_type                  cmp_res;

   skt_ram #(
      .WIDTH(KEY_W),
      .DEPTH(CAPACITY)
   ) u_ram (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   skt_cmp u_cmp (
      .entry (ram_rd_data),
      .key   (cmp_key),
      .result(cmp_res)
   );

   skt_ctrl #(
      .CAPACITY(CAPACITY)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req_kind    (req_tuser),
      .req_key     (req_tdata),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp_status  (rsp_status),
      .rsp_position(rsp_position),
      .rsp_count   (rsp_count),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data),
      .cmp_key     (cmp_key),
      .cmp_res     (cmp_res)
   );

   assign rsp_tdata = {4'b0000, rsp_count, rsp_position, rsp_status};

endmodule

FILE: test/tb.sv
// self-checking testbench of the sorted key table: directed and random insert, delete, search
`timescale 1ns / 100ps

module tb;
   import skt_pkg::*;

   localparam int CAPACITY = DEF_CAPACITY;
   localparam int STALL_LIMIT = 2000;
   localparam int SETTLE_CYCLES = 2 * (CAPACITY + 3);
   localparam int RANDOM_ITEMS = 800;
   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [POS_W-1:0]    position;
      logic [COUNT_W-1:0]  count;
   } table_result_t;

   typedef struct {
      logic [KIND_W-1:0] kind;
      logic [KEY_W-1:0]  key;
      int                phase;
      bit                wait_drain;
   } table_request_t;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;   // key[7:0]
   logic [1:0]  req_tuser = '0;   // kind[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;        // status[1:0], position[6:2], count[11:7]

   logic signed [KEY_W-1:0] key_store [CAPACITY];
   int held_keys = 0;
   int peak_held = 0;

   table_result_t  expected_results [$];
   table_request_t pending_reqs [$];
   table_request_t next_req;
   table_result_t  got_result;
   table_result_t  want_result;

   int total_reqs = 0;
   int accepted_reqs = 0;
   int fail_count = 0;
   int idle_cycles = 0;
   int active_phase = 0;
   int kind_seen [4] = '{default: 0};
   int status_seen [4] = '{default: 0};
   int send_idle_pct [3] = '{8, 67, 0};
   int recv_stall_pct [3] = '{67, 8, 0};
   bit req_taken = 1'b0;

   sorted_key_table_top #(.CAPACITY(CAPACITY)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // ordered table update and the result word it yields
   function automatic table_result_t apply_table_op(input logic [KIND_W-1:0] kind,
                                                    input logic signed [KEY_W-1:0] key);
      table_result_t res;
      int slot;
      res = '{status: ST_OK, position: '0, count: '0};
      slot = 0;
      case (kind) inside
         KIND_INSERT: begin
            if (held_keys >= CAPACITY) begin
               res.status = ST_FULL;
            end else begin
               // equal keys stay in arrival order
               while (slot < held_keys && key_store[slot] <= key) slot++;
               for (int j = held_keys; j > slot; j--) key_store[j] = key_store[j - 1];
               key_store[slot] = key;
               held_keys++;
               res.position = POS_W'(slot + 1);
            end
         end
         KIND_DELETE, KIND_SEARCH: begin
            if (held_keys == 0) begin
               res.status = ST_EMPTY;
            end else begin
               while (slot < held_keys && key_store[slot] != key) slot++;
               if (slot == held_keys) begin
                  res.status = ST_NOT_FOUND;
               end else begin
                  res.position = POS_W'(slot + 1);
                  if (kind == KIND_DELETE) begin
                     for (int j = slot; j < held_keys - 1; j++) key_store[j] = key_store[j + 1];
                     held_keys--;
                  end
               end
            end
         end
         default: ;
      endcase
      res.count = COUNT_W'(held_keys);
      return res;
   endfunction

   task automatic add_req(input logic [KIND_W-1:0] kind, input logic [KEY_W-1:0] key,
                          input int phase, input bit wait_drain);
      table_request_t item;
      item.kind = kind;
      item.key = key;
      item.phase = phase;
      item.wait_drain = wait_drain;
      pending_reqs.push_back(item);
   endtask

   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (pending_reqs.size() != 0
             && !(pending_reqs[0].wait_drain && expected_results.size() != 0)
             && $urandom_range(99) >= send_idle_pct[pending_reqs[0].phase]) begin
            next_req = pending_reqs.pop_front();
            req_tvalid <= 1'b1;
            req_tdata <= next_req.key;
            req_tuser <= next_req.kind;
            active_phase <= next_req.phase;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      rsp_tready <= !reset && $urandom_range(99) >= recv_stall_pct[active_phase];
   end

   always @(posedge clock) begin
      req_taken <= !reset && req_tvalid && req_tready;
      if (!reset && req_tvalid && req_tready) begin
         want_result = apply_table_op(req_tuser, req_tdata);
         expected_results.push_back(want_result);
         accepted_reqs++;
         kind_seen[req_tuser]++;
         status_seen[want_result.status]++;
         if (held_keys > peak_held) peak_held = held_keys;
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_result.status = rsp_tdata[1:0];
         got_result.position = rsp_tdata[6:2];
         got_result.count = rsp_tdata[11:7];
         if (expected_results.size() == 0) begin
            $error("result word with no request outstanding: %h", rsp_tdata);
            fail_count++;
         end else begin
            want_result = expected_results.pop_front();
            if (got_result.status !== want_result.status) begin
               $error("status: expected %0d, got %0d", want_result.status, got_result.status);
               fail_count++;
            end
            if (got_result.position !== want_result.position) begin
               $error("position: expected %0d, got %0d",
                      want_result.position, got_result.position);
               fail_count++;
            end
            if (got_result.count !== want_result.count) begin
               $error("count: expected %0d, got %0d", want_result.count, got_result.count);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles + 1 >= STALL_LIMIT) begin
         $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
         $display("FAIL sorted_key_table_top");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : stimulus
      logic [KEY_W-1:0] fill_keys [CAPACITY];
      int insert_pct [3];
      int delete_pct [3];
      int search_pct [3];
      int n;
      int mode;
      int r;
      int phase;
      int prev_phase;
      logic [KIND_W-1:0] kind;
      logic [KEY_W-1:0] key;

      fill_keys = '{8'h7F, 8'h80, 8'h00, 8'h00, 8'hFF, 8'h01,
         8'h7F, 8'h80, 8'h40, 8'hC0, 8'h00, 8'h05, 8'h64, 8'h9C, 8'h21, 8'hDF};
      insert_pct = '{70, 15, 35};
      delete_pct = '{85, 75, 65};
      search_pct = '{97, 97, 95};

      // empty table
      add_req(KIND_SEARCH, 8'h00, 0, 1'b0);
      add_req(KIND_DELETE, 8'h80, 0, 1'b0);
      add_req(KIND_UNUSED, 8'hFF, 0, 1'b0);
      // single key that does not match stays put
      add_req(KIND_INSERT, 8'h2A, 0, 1'b0);
      add_req(KIND_DELETE, 8'h07, 0, 1'b0);
      add_req(KIND_SEARCH, 8'h2A, 0, 1'b0);
      add_req(KIND_DELETE, 8'h2A, 0, 1'b0);
      // fill with extremes and duplicates, then overflow
      foreach (fill_keys[i]) add_req(KIND_INSERT, fill_keys[i], 0, i == 0);
      add_req(KIND_INSERT, 8'h09, 0, 1'b0);
      add_req(KIND_SEARCH, 8'h00, 0, 1'b1);
      add_req(KIND_DELETE, 8'h00, 0, 1'b0);
      add_req(KIND_DELETE, 8'h63, 0, 1'b0);
      add_req(KIND_UNUSED, 8'h00, 0, 1'b0);

      // bursts that lean toward filling, draining or neither
      n = 0;
      prev_phase = -1;
      while (n < RANDOM_ITEMS) begin
         mode = $urandom_range(2);
         repeat ($urandom_range(60, 10)) begin
            if (n < RANDOM_ITEMS) begin
               phase = n * 3 / RANDOM_ITEMS;
               r = $urandom_range(99);
               if (r < insert_pct[mode]) kind = KIND_INSERT;
               else if (r < delete_pct[mode]) kind = KIND_DELETE;
               else if (r < search_pct[mode]) kind = KIND_SEARCH;
               else kind = KIND_UNUSED;
               case ($urandom_range(5))
                  0: key = 8'h80 + 8'($urandom_range(3));
                  1: key = 8'hFE + 8'($urandom_range(3));
                  2: key = 8'h7C + 8'($urandom_range(3));
                  default: key = 8'($urandom_range(255));
               endcase
               add_req(kind, key, phase, phase != prev_phase || $urandom_range(39) == 0);
               prev_phase = phase;
               n++;
            end
         end
      end
      total_reqs = pending_reqs.size();

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (!(accepted_reqs == total_reqs && expected_results.size() == 0)) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("covered %0d requests: %0d insert, %0d delete, %0d search, %0d unused kind",
               accepted_reqs, kind_seen[KIND_INSERT], kind_seen[KIND_DELETE],
               kind_seen[KIND_SEARCH], kind_seen[KIND_UNUSED]);
      $display("outcomes: %0d ok, %0d not found, %0d empty, %0d full; peak fill %0d of %0d",
               status_seen[ST_OK], status_seen[ST_NOT_FOUND], status_seen[ST_EMPTY],
               status_seen[ST_FULL], peak_held, CAPACITY);
      if (fail_count == 0) begin
         $display("PASS sorted_key_table_top");
      end else begin
         $display("FAIL sorted_key_table_top");
      end
      $finish;
   end

endmodule
